// ----- design/plid_pkg.sv -----
// Shared types and codes for the positional list unit.
// No dependencies; imported by the cell, the top level and the checker.
`default_nettype none

package plid_pkg;

    // Fixed field widths of the stream words
    localparam int unsigned FUNC_W = 3;
    localparam int unsigned POS_W  = 7;
    localparam int unsigned VAL_W  = 32;
    localparam int unsigned STAT_W = 2;
    localparam int unsigned LEN_W  = 7;
    localparam int unsigned IN_W   = 48;
    localparam int unsigned OUT_W  = 48;

    // Cells per registered OR group on the read path
    localparam int unsigned GRP_SZ = 32;

    typedef enum logic [FUNC_W-1:0] {
        FN_CLEAR  = 3'd0,
        FN_APPEND = 3'd1,
        FN_INSERT = 3'd2,
        FN_DELETE = 3'd3,
        FN_READ   = 3'd4
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE   = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADPOS = 2'd2
    } t_status;

    // Shift command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic del;
    } t_cell_op;

endpackage

`default_nettype wire

// ----- design/plid_cell.sv -----
// One storage cell of the list: holds one entry and trades it with its neighbors.
// Depends on plid_pkg for the shift command type.
`default_nettype none

module plid_cell
    import plid_pkg::*;
#(
    parameter int unsigned CW  = 7,
    parameter int unsigned IDX = 0
) (
    input  wire logic             i_clk,
    input  wire t_cell_op         i_op,
    input  wire logic [CW-1:0]    i_pos,
    input  wire logic [VAL_W-1:0] i_val,
    input  wire logic [VAL_W-1:0] i_left,
    input  wire logic [VAL_W-1:0] i_right,
    output logic      [VAL_W-1:0] o_val,
    output logic      [VAL_W-1:0] o_tap
);

    localparam logic [CW-1:0] IDX_C = CW'(IDX);

    logic [VAL_W-1:0] r_val;
    logic [VAL_W-1:0] n_val;
    logic             w_hit;
    logic             w_past;

    assign w_hit  = (IDX_C == i_pos);
    assign w_past = (IDX_C > i_pos);

    // insert: cells past the slot take the left word, the slot takes the new word
    // delete: the slot and all cells past it take the right word
    always_comb begin
        n_val = r_val;
        if (i_op.ins) begin
            if (w_past) begin
                n_val = i_left;
            end else if (w_hit) begin
                n_val = i_val;
            end
        end else if (i_op.del) begin
            if (w_past || w_hit) begin
                n_val = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;
    // only the addressed cell drives the read OR tree
    assign o_tap = w_hit ? r_val : '0;

endmodule

`default_nettype wire

// ----- design/positional_list_insert_delete_unit.sv -----
// Top level of the positional list unit: count, op decode, cell chain, read path.
// Depends on plid_pkg and plid_cell.
//
//  channel  | dir | handshake               | payload
//  ---------+-----+-------------------------+----------------------------------
//  s (cmd)  | in  | i_s_tvalid / o_s_tready | func, position, value
//  m (resp) | out | o_m_tvalid / i_m_tready | data, status, length
//
// One word is accepted per cycle while o_s_tready is high; all cells shift together
// at the accept edge. The response passes a registered OR per group of 32 cells,
// then an OR across the groups into the response register.
// Reset clears the count and the pipeline valids; cell contents are not cleared.
// A stalled response holds the pipeline; o_s_tready drops only when both stages are full.
`default_nettype none

module positional_list_insert_delete_unit
    import plid_pkg::*;
#(
    parameter int unsigned CAPACITY = 64
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_tvalid,
    output logic                  o_s_tready,
    // [2:0] func, [9:3] position, [41:10] value, [47:42] zero
    input  wire logic [IN_W-1:0]  i_s_tdata,
    output logic                  o_m_tvalid,
    input  wire logic             i_m_tready,
    // [31:0] data, [33:32] status, [40:34] length, [47:41] zero
    output logic      [OUT_W-1:0] o_m_tdata
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned MW = (CW > POS_W) ? CW : POS_W;
    localparam int unsigned NG = (CAPACITY + GRP_SZ - 1) / GRP_SZ;
    localparam logic [MW-1:0] CAP_M = MW'(CAPACITY);

    // input fields
    logic [FUNC_W-1:0] w_func;
    logic [POS_W-1:0]  w_position;
    logic [VAL_W-1:0]  w_value;

    assign w_func     = i_s_tdata[FUNC_W-1:0];
    assign w_position = i_s_tdata[FUNC_W+POS_W-1:FUNC_W];
    assign w_value    = i_s_tdata[FUNC_W+POS_W+VAL_W-1:FUNC_W+POS_W];

    // pipeline handshake
    logic w_fire;
    logic w_s2_load;
    logic r_s1_v;
    logic r_s2_v;

    assign w_s2_load  = !r_s2_v || i_m_tready;
    assign o_s_tready = !r_s1_v || w_s2_load;
    assign w_fire     = i_s_tvalid && o_s_tready;

    // op decode against the current count
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [MW-1:0] w_pos_m;
    logic [MW-1:0] w_cnt_m;
    logic [CW-1:0] w_cell_pos;
    t_cell_op      w_op;
    t_status       w_status;
    logic          w_rd;

    assign w_pos_m = MW'(w_position);
    assign w_cnt_m = MW'(r_count);

    always_comb begin
        n_count    = r_count;
        w_op       = '0;
        w_status   = ST_DONE;
        w_rd       = 1'b0;
        w_cell_pos = CW'(w_pos_m);
        unique case (t_func'(w_func))
            FN_CLEAR: begin
                n_count = '0;
            end
            FN_APPEND: begin
                w_cell_pos = r_count;
                if (w_cnt_m >= CAP_M) begin
                    w_status = ST_FULL;
                end else begin
                    w_op.ins = 1'b1;
                    n_count  = CW'(r_count + 1'b1);
                end
            end
            FN_INSERT: begin
                if (w_pos_m > w_cnt_m) begin
                    w_status = ST_BADPOS;
                end else if (w_cnt_m >= CAP_M) begin
                    w_status = ST_FULL;
                end else begin
                    w_op.ins = 1'b1;
                    n_count  = CW'(r_count + 1'b1);
                end
            end
            FN_DELETE: begin
                if (w_pos_m >= w_cnt_m) begin
                    w_status = ST_BADPOS;
                end else begin
                    w_op.del = 1'b1;
                    w_rd     = 1'b1;
                    n_count  = CW'(r_count - 1'b1);
                end
            end
            FN_READ: begin
                if (w_pos_m >= w_cnt_m) begin
                    w_status = ST_BADPOS;
                end else begin
                    w_rd = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // commands reach the cells only on an accepted word
    t_cell_op w_op_g;
    assign w_op_g = w_fire ? w_op : '0;

    // cell chain
    logic [VAL_W-1:0] w_cval [CAPACITY];
    logic [VAL_W-1:0] w_tap  [CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [VAL_W-1:0] w_left;
        logic [VAL_W-1:0] w_right;
        if (i == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_cval[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign w_right = w_cval[i];
        end else begin : g_mid_r
            assign w_right = w_cval[i+1];
        end
        plid_cell #(
            .CW  (CW),
            .IDX (i)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (w_op_g),
            .i_pos   (w_cell_pos),
            .i_val   (w_value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_val   (w_cval[i]),
            .o_tap   (w_tap[i])
        );
    end

    // stage 1: OR of the taps per group, captured before the shift lands
    logic [VAL_W-1:0] w_grp [NG];
    logic [VAL_W-1:0] r_grp [NG];

    for (genvar g = 0; g < NG; g++) begin : g_grp
        logic [VAL_W-1:0] w_gtap [GRP_SZ];
        for (genvar k = 0; k < GRP_SZ; k++) begin : g_tap
            if (g * GRP_SZ + k < CAPACITY) begin : g_used
                assign w_gtap[k] = w_tap[g*GRP_SZ+k];
            end else begin : g_pad
                assign w_gtap[k] = '0;
            end
        end
        always_comb begin
            w_grp[g] = '0;
            for (int k = 0; k < GRP_SZ; k++) begin
                w_grp[g] = w_grp[g] | w_gtap[k];
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_fire) begin
                r_grp[g] <= w_grp[g];
            end
        end
    end

    logic             r_s1_rd;
    t_status          r_s1_status;
    logic [LEN_W-1:0] r_s1_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_s1_v  <= 1'b0;
        end else begin
            if (w_fire) begin
                r_count <= n_count;
            end
            if (o_s_tready) begin
                r_s1_v <= w_fire;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_s1_rd     <= w_rd;
            r_s1_status <= w_status;
            r_s1_len    <= LEN_W'(MW'(n_count));
        end
    end

    // stage 2: OR across groups into the response register
    logic [VAL_W-1:0] w_rdata;

    always_comb begin
        w_rdata = '0;
        for (int g = 0; g < NG; g++) begin
            w_rdata = w_rdata | r_grp[g];
        end
    end

    logic [VAL_W-1:0] r_data;
    t_status          r_status;
    logic [LEN_W-1:0] r_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (w_s2_load) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_load && r_s1_v) begin
            r_data   <= r_s1_rd ? w_rdata : '0;
            r_status <= r_s1_status;
            r_len    <= r_s1_len;
        end
    end

    assign o_m_tvalid = r_s2_v;
    assign o_m_tdata  = {(OUT_W - VAL_W - STAT_W - LEN_W)'(0), r_len, r_status, r_data};

endmodule

`default_nettype wire

// ----- design/plid_checker.sv -----
// Port-level checks for the positional list unit, bound to the top level.
// Depends on plid_pkg for field widths and status codes.
`default_nettype none

module plid_checker
    import plid_pkg::*;
#(
    parameter int unsigned CAPACITY = 64
) (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_s_tvalid,
    input wire logic             o_s_tready,
    input wire logic [IN_W-1:0]  i_s_tdata,
    input wire logic             o_m_tvalid,
    input wire logic             i_m_tready,
    input wire logic [OUT_W-1:0] o_m_tdata
);

    logic [VAL_W-1:0]  w_data;
    logic [STAT_W-1:0] w_stat;
    logic [LEN_W-1:0]  w_len;
    logic              w_in_word;

    assign w_data    = o_m_tdata[VAL_W-1:0];
    assign w_stat    = o_m_tdata[VAL_W+STAT_W-1:VAL_W];
    assign w_len     = o_m_tdata[VAL_W+STAT_W+LEN_W-1:VAL_W+STAT_W];
    assign w_in_word = i_s_tvalid && o_s_tready && (i_s_tdata[IN_W-1] == 1'b0);

    // stalled response word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("response changed while stalled");

    // a full report only comes with a full list
    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (w_stat == ST_FULL) |-> (32'(w_len) == 32'(CAPACITY)))
        else $error("full status with short list");

    // errors never carry data
    a_err_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (w_stat != ST_DONE) |-> (w_data == '0))
        else $error("error response with nonzero data");

    // an accepted word with a clear top bit, taken while no response is waiting, is followed by a valid response
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_word && !o_m_tvalid |=> ##1 o_m_tvalid)
        else $error("response missing after accepted word");

endmodule

bind positional_list_insert_delete_unit plid_checker #(.CAPACITY(CAPACITY)) u_plid_checker (.*);

`default_nettype wire

// ----- sim/plid_list_checker.sv -----
// Scoreboard for the positional list unit: watches both stream channels,
// predicts each response word and compares it field by field. Uses plid_pkg.
module plid_list_checker
    import plid_pkg::*;
#(
    parameter int unsigned CAPACITY = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  logic             i_s_tready,
    // [2:0] func, [9:3] position, [41:10] value, [47:42] zero
    input  logic [IN_W-1:0]  i_s_tdata,
    input  logic             i_m_tvalid,
    input  logic             i_m_tready,
    // [31:0] data, [33:32] status, [40:34] length, [47:41] zero
    input  logic [OUT_W-1:0] i_m_tdata,
    output int               o_errors,
    output int               o_pending,
    output int               o_checked,
    output int               o_full_cnt,
    output int               o_badpos_cnt
);

    typedef struct packed {
        logic [VAL_W-1:0] data;
        t_status          status;
        logic [LEN_W-1:0] length;
    } t_list_resp;

    // Shadow copy of the list
    logic [VAL_W-1:0] list_cells [CAPACITY];
    int unsigned      list_len;
    t_list_resp       resp_due_q [$];

    initial begin
        o_errors     = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_full_cnt   = 0;
        o_badpos_cnt = 0;
        list_len     = 0;
    end

    // Apply one command word to the shadow list and return its response
    task automatic apply_list_cmd(input logic [IN_W-1:0] word, output t_list_resp resp);
        logic [FUNC_W-1:0] fn;
        int unsigned       pos;
        logic [VAL_W-1:0]  val;
        int unsigned       i;
        fn          = word[FUNC_W-1:0];
        pos         = 32'(word[FUNC_W +: POS_W]);
        val         = word[FUNC_W+POS_W +: VAL_W];
        resp.data   = '0;
        resp.status = ST_DONE;
        case (fn)
            FN_CLEAR: begin
                list_len = 0;
            end
            FN_APPEND: begin
                if (list_len >= CAPACITY) begin
                    resp.status = ST_FULL;
                end else begin
                    list_cells[list_len] = val;
                    list_len++;
                end
            end
            FN_INSERT: begin
                // position is checked ahead of fullness
                if (pos > list_len) begin
                    resp.status = ST_BADPOS;
                end else if (list_len >= CAPACITY) begin
                    resp.status = ST_FULL;
                end else begin
                    for (i = list_len; i > pos; i--)
                        list_cells[i] = list_cells[i-1];
                    list_cells[pos] = val;
                    list_len++;
                end
            end
            FN_DELETE: begin
                if (pos >= list_len) begin
                    resp.status = ST_BADPOS;
                end else begin
                    resp.data = list_cells[pos];
                    for (i = pos; i + 1 < list_len; i++)
                        list_cells[i] = list_cells[i+1];
                    list_len--;
                end
            end
            FN_READ: begin
                if (pos >= list_len)
                    resp.status = ST_BADPOS;
                else
                    resp.data = list_cells[pos];
            end
            default: begin
                // unused codes: no effect
            end
        endcase
        resp.length = LEN_W'(list_len);
    endtask

    // Predict on accepted commands, compare on accepted responses
    always @(posedge i_clk) begin : track
        t_list_resp due;
        t_list_resp got;
        if (!i_rst_n) begin
            list_len = 0;
            resp_due_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                apply_list_cmd(i_s_tdata, due);
                resp_due_q.push_back(due);
                if (due.status == ST_FULL)
                    o_full_cnt++;
                if (due.status == ST_BADPOS)
                    o_badpos_cnt++;
            end
            if (i_m_tvalid && i_m_tready) begin
                got.data   = i_m_tdata[31:0];
                got.status = t_status'(i_m_tdata[33:32]);
                got.length = i_m_tdata[40:34];
                o_checked++;
                if (resp_due_q.size() == 0) begin
                    $display("%0t: unexpected response word data=%h status=%0d length=%0d",
                             $time, got.data, got.status, got.length);
                    o_errors++;
                end else begin
                    due = resp_due_q.pop_front();
                    if (got.data !== due.data) begin
                        $display("%0t: data mismatch: expected %h, got %h",
                                 $time, due.data, got.data);
                        o_errors++;
                    end
                    if (got.status !== due.status) begin
                        $display("%0t: status mismatch: expected %0d, got %0d",
                                 $time, due.status, got.status);
                        o_errors++;
                    end
                    if (got.length !== due.length) begin
                        $display("%0t: length mismatch: expected %0d, got %0d",
                                 $time, due.length, got.length);
                        o_errors++;
                    end
                end
            end
        end
        o_pending = resp_due_q.size();
    end

endmodule

// ----- sim/positional_list_insert_delete_unit_test.sv -----
// Testbench top for the positional list unit: clock, reset, command stimulus,
// response back-pressure and verdict. Depends on plid_pkg, the top level and plid_list_checker.
module positional_list_insert_delete_unit_test;
    import plid_pkg::*;

    localparam int unsigned CAPACITY      = 64;
    localparam int unsigned PHASE_ITEMS   = 230;
    localparam int unsigned HOLD_CYCLES   = 60;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned RUN_LIMIT     = 1_000_000;

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             s_tvalid = 1'b0;
    logic [IN_W-1:0]  s_tdata  = '0;
    logic             m_tready = 1'b0;
    logic             s_tready;
    logic             m_tvalid;
    logic [OUT_W-1:0] m_tdata;

    int chk_errors;
    int resp_pending;
    int resp_checked;
    int full_cnt;
    int badpos_cnt;

    // Stimulus knobs and bookkeeping
    int unsigned send_idle_pct = 0;
    int unsigned rcv_stall_pct = 0;
    int unsigned fill_level    = 0;
    int unsigned cmds_sent     = 0;
    bit          long_hold_req = 1'b0;

    always #1 clk = ~clk;

    positional_list_insert_delete_unit #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    plid_list_checker #(
        .CAPACITY(CAPACITY)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_errors     (chk_errors),
        .o_pending    (resp_pending),
        .o_checked    (resp_checked),
        .o_full_cnt   (full_cnt),
        .o_badpos_cnt (badpos_cnt)
    );

    // Hard stop if the run hangs
    initial begin
        #(RUN_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // Response side: random stalls, or one long hold-off on request
    initial begin
        forever begin
            @(posedge clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end else begin
                m_tready <= ($urandom_range(99) >= rcv_stall_pct);
            end
        end
    end

    // Values biased toward the extremes
    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '0;
            3:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // Offer one command word and wait until it is taken
    task automatic push_cmd(input logic [FUNC_W-1:0] fn, input logic [POS_W-1:0] pos,
                            input logic [VAL_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_W-FUNC_W-POS_W-VAL_W){1'b0}}, val, pos, fn};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        cmds_sent++;
        // track the list length only to aim positions
        case (fn)
            FN_CLEAR:  fill_level = 0;
            FN_APPEND: if (fill_level < CAPACITY) fill_level++;
            FN_INSERT: if (pos <= fill_level && fill_level < CAPACITY) fill_level++;
            FN_DELETE: if (pos < fill_level) fill_level--;
            default:   ;
        endcase
    endtask

    // Stop offering until every response has come back
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (resp_pending != 0) @(posedge clk);
    endtask

    function automatic logic [POS_W-1:0] live_pos();
        return (fill_level == 0) ? '0 : POS_W'($urandom_range(fill_level - 1, 0));
    endfunction

    // One random command: mostly valid positions, some noise
    task automatic random_cmd();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 10)
            push_cmd(FUNC_W'($urandom_range(7)), POS_W'($urandom_range(127)), $urandom());
        else if (pick < 12)
            push_cmd(FUNC_W'($urandom_range(7, 5)), POS_W'($urandom_range(127)), $urandom());
        else if (pick < 13)
            push_cmd(FN_CLEAR, POS_W'($urandom_range(127)), $urandom());
        else if (pick < 30)
            push_cmd(FN_APPEND, POS_W'($urandom_range(127)), rand_value());
        else if (pick < 52)
            push_cmd(FN_INSERT, POS_W'($urandom_range(fill_level, 0)), rand_value());
        else if (pick < 75)
            push_cmd(FN_DELETE, live_pos(), $urandom());
        else
            push_cmd(FN_READ, live_pos(), $urandom());
    endtask

    // Grow the list to capacity, poke at the full list, then shrink it again
    task automatic fill_and_spill();
        while (fill_level < CAPACITY) begin
            if ($urandom_range(1))
                push_cmd(FN_APPEND, POS_W'($urandom_range(127)), rand_value());
            else
                push_cmd(FN_INSERT, POS_W'($urandom_range(fill_level, 0)), rand_value());
        end
        push_cmd(FN_APPEND, POS_W'($urandom_range(127)), rand_value());
        push_cmd(FN_INSERT, POS_W'(CAPACITY), rand_value());
        push_cmd(FN_INSERT, POS_W'($urandom_range(CAPACITY - 1, 0)), rand_value());
        push_cmd(FN_INSERT, POS_W'(CAPACITY + 1), rand_value());
        push_cmd(FN_READ, POS_W'(CAPACITY - 1), $urandom());
        push_cmd(FN_READ, POS_W'(CAPACITY), $urandom());
        repeat (40) push_cmd(FN_DELETE, live_pos(), $urandom());
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty list, extremes, ends and middle, bad positions, unused codes
        push_cmd(FN_CLEAR, 0, 0);
        push_cmd(FN_READ, 0, 0);
        push_cmd(FN_DELETE, 0, 0);
        push_cmd(FN_INSERT, 1, 32'h1111_1111);
        push_cmd(FN_INSERT, 0, 32'h8000_0000);
        push_cmd(FN_APPEND, 0, 32'h7FFF_FFFF);
        push_cmd(FN_APPEND, 0, 32'hFFFF_FFFF);
        push_cmd(FN_INSERT, 3, 32'h0000_0000);
        push_cmd(FN_INSERT, 1, 32'h5A5A_5A5A);
        push_cmd(FN_INSERT, 6, 32'h2222_2222);
        push_cmd(FN_INSERT, 127, 32'h3333_3333);
        push_cmd(FN_READ, 0, 0);
        push_cmd(FN_READ, 4, 0);
        push_cmd(FN_READ, 5, 0);
        push_cmd(FN_READ, 127, 32'hFFFF_FFFF);
        push_cmd(FN_DELETE, 4, 0);
        push_cmd(FN_DELETE, 0, 0);
        push_cmd(FN_DELETE, 1, 0);
        push_cmd(FN_DELETE, 2, 0);
        push_cmd(FN_DELETE, 127, 0);
        push_cmd(3'd5, POS_W'($urandom_range(127)), $urandom());
        push_cmd(3'd6, POS_W'($urandom_range(127)), $urandom());
        push_cmd(3'd7, POS_W'($urandom_range(127)), $urandom());
        push_cmd(FN_CLEAR, 127, 32'hFFFF_FFFF);
        push_cmd(FN_READ, 0, 0);
        wait_for_drain();

        // Random phases with different idle and stall mixes
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin send_idle_pct = 0;  rcv_stall_pct = 0;  end
                1:       begin send_idle_pct = 73; rcv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  rcv_stall_pct = 73; end
                default: begin send_idle_pct = 20; rcv_stall_pct = 20; end
            endcase
            // back-pressure the pipeline until the input stalls
            if (ph == 0)
                long_hold_req = 1'b1;
            fill_and_spill();
            repeat (PHASE_ITEMS) random_cmd();
            wait_for_drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        $display("Run covered %0d command words in four idle/stall mixes plus directed cases.",
                 cmds_sent);
        $display("%0d responses checked, %0d list-full and %0d bad-position refusals.",
                 resp_checked, full_cnt, badpos_cnt);
        if (chk_errors == 0 && resp_pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
design/plid_pkg.sv
design/plid_cell.sv
design/positional_list_insert_delete_unit.sv
design/plid_checker.sv
sim/plid_list_checker.sv
sim/positional_list_insert_delete_unit_test.sv
